// ----- hw/rtl/lifeg_pkg.sv -----
`timescale 1ns / 1ps

package lifeg_pkg;

   // field and register widths
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int ROWS_REG_W  = 6;
   localparam int COLS_REG_W  = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int COUNT_W     = 4;

   // request codes
   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_ADVANCE = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;

   // register indexes
   localparam logic CSR_ACTIVE_ROWS = 1'b0;
   localparam logic CSR_ACTIVE_COLS = 1'b1;

   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd25;
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd65;

   // b3/s23
   localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_LOW = 4'd2;

endpackage

// ----- hw/rtl/life_automaton_grid_step.sv -----
`timescale 1ns / 1ps

// channel   direction  ports                                           handshake
// req       in         req_type, req_cell_row, req_cell_col,           req_valid / req_ready
//                      req_cell_value
// rsp       out        rsp_read_value, rsp_neighbour_count,            rsp_valid / rsp_ready
//                      rsp_out_of_range
// csr       in         csr_index, csr_data                             csr_valid / csr_ready
//
// one beat at a time; the grid lives in a row-wide ram and every row goes through
// one shared neighbour/rule unit. a write reads and rewrites its row, a read fetches
// the rows around the cell, an advance takes one row per cycle (rows saturated at the
// grid size); out-of-range, unknown or zero-row advance requests skip straight to rsp.
// reset clears per-row valid bits at once, so the grid reads dead with no sweep.
// a new req beat is taken while an earlier rsp beat still waits; the sequencer
// only holds its last cycle while the rsp register is full.

module life_automaton_grid_step #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 128
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [lifeg_pkg::ROW_FIELD_W-1:0]   req_cell_row,
   input  logic [lifeg_pkg::COL_FIELD_W-1:0]   req_cell_col,
   input  logic                                req_cell_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_read_value,
   output logic [lifeg_pkg::COUNT_W-1:0]       rsp_neighbour_count,
   output logic                                rsp_out_of_range,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [lifeg_pkg::CSR_DATA_W-1:0]    csr_data
);

   import lifeg_pkg::*;

   localparam int RAW    = $clog2(MAX_ROWS);
   localparam int CAW    = $clog2(MAX_COLS);
   localparam int RCNT_W = ($clog2(MAX_ROWS + 1) > ROWS_REG_W) ? $clog2(MAX_ROWS + 1)
                                                               : ROWS_REG_W;
   localparam int CCNT_W = ($clog2(MAX_COLS + 1) > COLS_REG_W) ? $clog2(MAX_COLS + 1)
                                                               : COLS_REG_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_W_RD,
      ST_W_WR,
      ST_R_UP,
      ST_R_MID,
      ST_R_DN,
      ST_R_CNT,
      ST_G_START,
      ST_G_LOAD,
      ST_G_ROW,
      ST_FIN
   } state_type;

   state_type               state_ff;
   logic [ROWS_REG_W-1:0]   active_rows_ff;
   logic [COLS_REG_W-1:0]   active_cols_ff;
   logic [1:0]              type_ff;
   logic [RCNT_W-1:0]       row_ff;
   logic [CAW-1:0]          col_ff;
   logic                    val_ff;
   logic [RCNT_W-1:0]       row_cnt_ff;
   logic [MAX_COLS-1:0]     above_ff;
   logic [MAX_COLS-1:0]     here_ff;
   logic [MAX_COLS-1:0]     below_ff;
   logic                    res_oor_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_value_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic                    rsp_oor_ff;
   logic [MAX_ROWS-1:0]     row_vld_ff;
   logic                    rd_vld_ff;

   logic [RCNT_W-1:0]       eff_rows;
   logic [CCNT_W-1:0]       eff_cols;
   logic [MAX_COLS-1:0]     col_mask;
   logic [RCNT_W-1:0]       in_row;
   logic [CCNT_W-1:0]       in_col;
   logic                    in_bad;
   logic [RCNT_W:0]         row_p1;
   logic [RCNT_W:0]         cnt_p1;
   logic [RCNT_W:0]         cnt_p2;
   logic                    row_has_below;
   logic                    gen_has_below;
   logic                    gen_has_next2;
   logic                    out_free;
   logic                    rd_hit;
   logic [RAW-1:0]          rd_addr;
   logic                    wr_en;
   logic [RAW-1:0]          wr_addr;
   logic [MAX_COLS-1:0]     wr_data;
   logic [MAX_COLS-1:0]     ram_rd_data;
   logic [MAX_COLS-1:0]     rd_row;
   logic [MAX_COLS-1:0]     cell_set_row;
   logic [MAX_COLS-1:0]     unit_below;
   logic [MAX_COLS-1:0]     fresh_row;
   logic [COUNT_W-1:0]      sel_count;

   // active area, saturated at the grid size
   assign eff_rows = (RCNT_W'(active_rows_ff) > RCNT_W'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS)
                                                                   : RCNT_W'(active_rows_ff);
   assign eff_cols = (CCNT_W'(active_cols_ff) > CCNT_W'(MAX_COLS)) ? CCNT_W'(MAX_COLS)
                                                                   : CCNT_W'(active_cols_ff);

   always_comb begin
      for (int i = 0; i < MAX_COLS; i++) begin
         col_mask[i] = CCNT_W'(i) < eff_cols;
      end
   end

   assign in_row = RCNT_W'(req_cell_row);
   assign in_col = CCNT_W'(req_cell_col);
   assign in_bad = (in_row >= eff_rows) || (in_col >= eff_cols);

   assign row_p1        = {1'b0, row_ff} + 1'b1;
   assign cnt_p1        = {1'b0, row_cnt_ff} + 1'b1;
   assign cnt_p2        = {1'b0, row_cnt_ff} + 2'd2;
   assign row_has_below = row_p1 < {1'b0, eff_rows};
   assign gen_has_below = cnt_p1 < {1'b0, eff_rows};
   assign gen_has_next2 = cnt_p2 < {1'b0, eff_rows};

   assign out_free = !rsp_valid_ff || rsp_ready;

   // in-range read: value and count come straight from the held rows
   assign rd_hit = (type_ff == REQ_READ) && !res_oor_ff;

   // a row never written since reset reads as all dead
   assign rd_row = rd_vld_ff ? ram_rd_data : '0;

   always_comb begin
      cell_set_row         = rd_row;
      cell_set_row[col_ff] = val_ff;
   end

   always_comb begin
      case (state_ff)
         ST_W_RD:   rd_addr = row_ff[RAW-1:0];
         ST_R_UP:   rd_addr = (row_ff == '0) ? '0 : row_ff[RAW-1:0] - 1'b1;
         ST_R_MID:  rd_addr = row_ff[RAW-1:0];
         ST_R_DN:   rd_addr = row_has_below ? row_p1[RAW-1:0] : row_ff[RAW-1:0];
         ST_G_START: rd_addr = '0;
         ST_G_LOAD: rd_addr = gen_has_below ? cnt_p1[RAW-1:0] : row_cnt_ff[RAW-1:0];
         ST_G_ROW:  rd_addr = gen_has_next2 ? cnt_p2[RAW-1:0] : row_cnt_ff[RAW-1:0];
         default:   rd_addr = row_cnt_ff[RAW-1:0];
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_W_WR: begin
            wr_en   = 1'b1;
            wr_addr = row_ff[RAW-1:0];
            wr_data = cell_set_row;
         end
         ST_G_ROW: begin
            wr_en   = 1'b1;
            wr_addr = row_cnt_ff[RAW-1:0];
            wr_data = fresh_row;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = row_cnt_ff[RAW-1:0];
            wr_data = fresh_row;
         end
      endcase
   end

   assign unit_below = (state_ff == ST_G_ROW) ? (gen_has_below ? rd_row : '0) : below_ff;

   lifeg_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   lifeg_row_unit #(
      .MAX_COLS (MAX_COLS)
   ) u_row (
      .above     (above_ff),
      .here      (here_ff),
      .below     (unit_below),
      .col_mask  (col_mask),
      .sel_col   (col_ff),
      .fresh     (fresh_row),
      .sel_count (sel_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_rows_ff <= ROWS_RESET;
         active_cols_ff <= COLS_RESET;
         row_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         row_vld_ff     <= '0;
         rd_vld_ff      <= 1'b0;
      end else begin
         rd_vld_ff <= row_vld_ff[rd_addr];
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
         end

         if (csr_valid) begin
            case (csr_index)
               CSR_ACTIVE_ROWS: active_rows_ff <= csr_data[ROWS_REG_W-1:0];
               CSR_ACTIVE_COLS: active_cols_ff <= csr_data[COLS_REG_W-1:0];
               default: ;
            endcase
         end

         // in ST_FIN a waiting beat either stays or is replaced below
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  type_ff      <= req_type;
                  row_ff       <= in_row;
                  col_ff       <= in_col[CAW-1:0];
                  val_ff       <= req_cell_value;
                  res_oor_ff   <= in_bad && (req_type == REQ_WRITE || req_type == REQ_READ);
                  row_cnt_ff   <= '0;
                  if (req_type == REQ_WRITE && !in_bad) begin
                     state_ff <= ST_W_RD;
                  end else if (req_type == REQ_READ && !in_bad) begin
                     state_ff <= ST_R_UP;
                  end else if (req_type == REQ_ADVANCE && eff_rows != '0) begin
                     state_ff <= ST_G_START;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_W_RD: begin
               state_ff <= ST_W_WR;
            end
            ST_W_WR: begin
               state_ff <= ST_FIN;
            end
            ST_R_UP: begin
               state_ff <= ST_R_MID;
            end
            ST_R_MID: begin
               above_ff <= (row_ff == '0) ? '0 : rd_row;
               state_ff <= ST_R_DN;
            end
            ST_R_DN: begin
               here_ff  <= rd_row;
               state_ff <= ST_R_CNT;
            end
            ST_R_CNT: begin
               below_ff <= row_has_below ? rd_row : '0;
               state_ff <= ST_FIN;
            end
            ST_G_START: begin
               state_ff <= ST_G_LOAD;
            end
            ST_G_LOAD: begin
               above_ff <= '0;
               here_ff  <= rd_row;
               state_ff <= ST_G_ROW;
            end
            ST_G_ROW: begin
               // old contents of this row become the row above for the next one
               above_ff <= here_ff;
               here_ff  <= rd_row;
               if (gen_has_below) begin
                  row_cnt_ff <= cnt_p1[RCNT_W-1:0];
               end else begin
                  row_cnt_ff <= '0;
                  state_ff   <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= rd_hit ? here_ff[col_ff] : 1'b0;
                  rsp_count_ff <= rd_hit ? sel_count : '0;
                  rsp_oor_ff   <= res_oor_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_value      = rsp_value_ff;
   assign rsp_neighbour_count = rsp_count_ff;
   assign rsp_out_of_range    = rsp_oor_ff;

endmodule

// ----- hw/rtl/lifeg_ram.sv -----
`timescale 1ns / 1ps

module lifeg_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lifeg_row_unit.sv -----
`timescale 1ns / 1ps

module lifeg_row_unit #(
   parameter int MAX_COLS = 128
) (
   input  logic [MAX_COLS-1:0]           above,
   input  logic [MAX_COLS-1:0]           here,
   input  logic [MAX_COLS-1:0]           below,
   input  logic [MAX_COLS-1:0]           col_mask,
   input  logic [$clog2(MAX_COLS)-1:0]   sel_col,
   output logic [MAX_COLS-1:0]           fresh,
   output logic [lifeg_pkg::COUNT_W-1:0] sel_count
);

   import lifeg_pkg::*;

   // one guard cell on each side so edge columns see dead neighbours
   logic [MAX_COLS+1:0]  a_pad;
   logic [MAX_COLS+1:0]  h_pad;
   logic [MAX_COLS+1:0]  b_pad;
   logic [COUNT_W-1:0]   nbr_cnt [MAX_COLS];

   assign a_pad = {1'b0, above & col_mask, 1'b0};
   assign h_pad = {1'b0, here & col_mask, 1'b0};
   assign b_pad = {1'b0, below & col_mask, 1'b0};

   for (genvar i = 0; i < MAX_COLS; i++) begin : g_col
      logic alive;

      assign nbr_cnt[i] = COUNT_W'(a_pad[i]) + COUNT_W'(a_pad[i+1]) + COUNT_W'(a_pad[i+2])
                        + COUNT_W'(h_pad[i]) + COUNT_W'(h_pad[i+2])
                        + COUNT_W'(b_pad[i]) + COUNT_W'(b_pad[i+1]) + COUNT_W'(b_pad[i+2]);

      assign alive = h_pad[i+1] ? (nbr_cnt[i] == SURVIVE_LOW || nbr_cnt[i] == BIRTH_COUNT)
                                : (nbr_cnt[i] == BIRTH_COUNT);

      // columns beyond the active area keep what they hold
      assign fresh[i] = col_mask[i] ? alive : here[i];
   end

   assign sel_count = nbr_cnt[sel_col];

endmodule
